// File: rtl/bounded_deque_with_value_delete_defines.svh
// Assertion macros shared by the deque RTL; they use the clk and rst_n of the including module.
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// Shared types and constants of the bounded deque.
package bdq_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int OPCODE_W = 4;
  localparam int KIND_W   = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_FRONT  = 4'd0,
    OP_ADD_BACK   = 4'd1,
    OP_DEL_FRONT  = 4'd2,
    OP_DEL_BACK   = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_DEL_VALUE  = 4'd5,
    OP_EMIT_FIRST = 4'd6,
    OP_EMIT_LAST  = 4'd7,
    OP_EMIT_ALL   = 4'd8
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ELEMENT = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROPPED = 2'd2
  } kind_t;

  typedef struct packed {
    opcode_t                    op;
    logic signed [VALUE_W-1:0]  value;
    logic        [COUNT_W-1:0]  count;
  } cmd_t;

endpackage

// File: rtl/bdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bdq_front.sv
// Input stage: accepts items and turns valid opcodes into queued commands.
module bdq_front (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bdq_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic signed [bdq_pkg::VALUE_W-1:0] in_value,
  input  logic [bdq_pkg::COUNT_W-1:0]      in_count,
  input  logic                             q_full,
  output logic                             q_push,
  output bdq_pkg::cmd_t                    q_cmd
);

  logic known_op;

  // Unused opcodes are accepted and dropped here; they never reach the back end.
  always_comb begin
    case (bdq_pkg::opcode_t'(in_opcode))
      bdq_pkg::OP_ADD_FRONT,
      bdq_pkg::OP_ADD_BACK,
      bdq_pkg::OP_DEL_FRONT,
      bdq_pkg::OP_DEL_BACK,
      bdq_pkg::OP_CLEAR,
      bdq_pkg::OP_DEL_VALUE,
      bdq_pkg::OP_EMIT_FIRST,
      bdq_pkg::OP_EMIT_LAST,
      bdq_pkg::OP_EMIT_ALL: known_op = 1'b1;
      default:              known_op = 1'b0;
    endcase
  end

  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full && known_op;
  assign q_cmd.op    = bdq_pkg::opcode_t'(in_opcode);
  assign q_cmd.value = in_value;
  assign q_cmd.count = in_count;

endmodule

// File: rtl/bdq_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
module bdq_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bdq_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bdq_pkg::cmd_t head_cmd,
  output logic          empty,
  output logic          full
);

  bdq_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign empty   = (fill_r == 2'd0);
  assign full    = (fill_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/bdq_back.sv
// Execution stage: owns the element store, the front index and count, and the result register.
`include "bounded_deque_with_value_delete_defines.svh"

module bdq_back #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bdq_pkg::cmd_t                      cmd,
  input  logic                               cmd_valid,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bdq_pkg::VALUE_W-1:0] out_element_value,
  output logic [bdq_pkg::KIND_W-1:0]         out_kind,
  output logic                               out_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int MW = (CW > bdq_pkg::COUNT_W) ? CW : bdq_pkg::COUNT_W;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_M1 = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SRCH  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // Store position of logical position pos; both operands stay below CAPACITY + 1.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] front, input logic [CW-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(front) + SW'(pos);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  state_t                      state_r, state_nxt;
  logic [IW-1:0]               front_r, front_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               rd_pos_r, rd_pos_nxt;
  logic [CW-1:0]               wr_pos_r, wr_pos_nxt;
  logic [CW-1:0]               issue_left_r, issue_left_nxt;
  logic [CW-1:0]               emit_left_r, emit_left_nxt;
  logic                        have_data_r, have_data_nxt;
  logic [bdq_pkg::VALUE_W-1:0] srch_value_r, srch_value_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bdq_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  bdq_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        ram_we, ram_re;
  logic [CW-1:0]               ram_wpos;
  logic [bdq_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0]               ram_waddr, ram_raddr;

  logic                        out_free, is_full, is_empty, need_out;
  logic [MW-1:0]               req_ext, cnt_ext, n_ext;
  logic [CW-1:0]               emit_n;
  logic                        is_add, is_emit;

  bdq_ram #(
    .WIDTH (bdq_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = slot(front_r, rd_pos_r);
  assign ram_waddr = slot(front_r, ram_wpos);

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    is_full  = (count_r == CAP_C);
    is_empty = (count_r == '0);
    is_add   = (cmd.op == bdq_pkg::OP_ADD_FRONT) || (cmd.op == bdq_pkg::OP_ADD_BACK);
    is_emit  = (cmd.op == bdq_pkg::OP_EMIT_FIRST) || (cmd.op == bdq_pkg::OP_EMIT_LAST) ||
               (cmd.op == bdq_pkg::OP_EMIT_ALL);
    req_ext  = MW'(cmd.count);
    cnt_ext  = MW'(count_r);
    n_ext    = (req_ext < cnt_ext) ? req_ext : cnt_ext;
    emit_n   = (cmd.op == bdq_pkg::OP_EMIT_ALL) ? count_r : n_ext[CW-1:0];
    need_out = (is_add && is_full) || (is_emit && (emit_n == '0));

    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    rd_pos_nxt     = rd_pos_r;
    wr_pos_nxt     = wr_pos_r;
    issue_left_nxt = issue_left_r;
    emit_left_nxt  = emit_left_r;
    have_data_nxt  = 1'b0;
    srch_value_nxt = srch_value_r;
    out_value_nxt  = out_value_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_wpos       = wr_pos_r;
    ram_wdata      = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && (!need_out || out_free)) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            bdq_pkg::OP_ADD_FRONT,
            bdq_pkg::OP_ADD_BACK: begin
              if (is_full) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                out_kind_nxt  = bdq_pkg::KIND_DROPPED;
                out_last_nxt  = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = cmd.value;
                count_nxt = count_r + ONE_C;
                if (cmd.op == bdq_pkg::OP_ADD_FRONT) begin
                  // One place before the front is logical position CAPACITY-1.
                  ram_wpos  = CAP_M1;
                  front_nxt = slot(front_r, CAP_M1);
                end else begin
                  ram_wpos = count_r;
                end
              end
            end
            bdq_pkg::OP_DEL_FRONT: begin
              if (!is_empty) begin
                front_nxt = slot(front_r, ONE_C);
                count_nxt = count_r - ONE_C;
              end
            end
            bdq_pkg::OP_DEL_BACK: begin
              if (!is_empty) begin
                count_nxt = count_r - ONE_C;
              end
            end
            bdq_pkg::OP_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            bdq_pkg::OP_DEL_VALUE: begin
              srch_value_nxt = cmd.value;
              rd_pos_nxt     = '0;
              state_nxt      = ST_SRCH;
            end
            bdq_pkg::OP_EMIT_FIRST,
            bdq_pkg::OP_EMIT_LAST,
            bdq_pkg::OP_EMIT_ALL: begin
              if (emit_n == '0) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                out_kind_nxt  = bdq_pkg::KIND_EMPTY;
                out_last_nxt  = 1'b1;
              end else begin
                rd_pos_nxt     = (cmd.op == bdq_pkg::OP_EMIT_LAST) ? (count_r - emit_n) : '0;
                issue_left_nxt = emit_n;
                emit_left_nxt  = emit_n;
                state_nxt      = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SRCH: begin
        // Reads stream one per cycle; the compare looks at the previous read.
        ram_re        = (rd_pos_r < count_r);
        have_data_nxt = ram_re;
        if (ram_re) begin
          rd_pos_nxt = rd_pos_r + ONE_C;
        end
        if (have_data_r && (ram_rdata == srch_value_r)) begin
          wr_pos_nxt = rd_pos_r - ONE_C;
          state_nxt  = ST_SHIFT;
        end else if (!have_data_r && !ram_re) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        // Each element behind the match moves one place toward the front.
        ram_re        = (rd_pos_r < count_r);
        have_data_nxt = ram_re;
        if (ram_re) begin
          rd_pos_nxt = rd_pos_r + ONE_C;
        end
        if (have_data_r) begin
          ram_we     = 1'b1;
          ram_wpos   = wr_pos_r;
          ram_wdata  = ram_rdata;
          wr_pos_nxt = wr_pos_r + ONE_C;
        end else begin
          count_nxt = count_r - ONE_C;
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        // The read register holds its data while the result register is blocked.
        ram_re        = (issue_left_r != '0) && (!have_data_r || out_free);
        have_data_nxt = ram_re || (have_data_r && !out_free);
        if (ram_re) begin
          rd_pos_nxt     = rd_pos_r + ONE_C;
          issue_left_nxt = issue_left_r - ONE_C;
        end
        if (have_data_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = ram_rdata;
          out_kind_nxt  = bdq_pkg::KIND_ELEMENT;
          out_last_nxt  = (emit_left_r == ONE_C);
          emit_left_nxt = emit_left_r - ONE_C;
          if (emit_left_r == ONE_C) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      front_r      <= '0;
      count_r      <= '0;
      rd_pos_r     <= '0;
      wr_pos_r     <= '0;
      issue_left_r <= '0;
      emit_left_r  <= '0;
      have_data_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      rd_pos_r     <= rd_pos_nxt;
      wr_pos_r     <= wr_pos_nxt;
      issue_left_r <= issue_left_nxt;
      emit_left_r  <= emit_left_nxt;
      have_data_r  <= have_data_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srch_value_r <= srch_value_nxt;
    out_value_r  <= out_value_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_element_value = out_value_r;
  assign out_kind          = out_kind_r;
  assign out_last          = out_last_r;

  `BDQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CAP_C, "element count above capacity")
  `BDQ_ASSERT_IMPL(a_write_state, ram_we, (state_r == ST_IDLE) || (state_r == ST_SHIFT), "store written outside insert or shift")
  `BDQ_ASSERT_IMPL(a_emit_track, state_r == ST_EMIT, emit_left_r == issue_left_r + CW'(have_data_r), "emit counters out of step")
  `BDQ_ASSERT_NEXT(a_shift_done, (state_r == ST_SHIFT) && !have_data_r, state_r == ST_IDLE, "shift did not finish")

endmodule

// File: rtl/bounded_deque_with_value_delete.sv
// Top level of the bounded double-ended queue with delete by value.
//
// Usage: commands enter on the in_ channel (in_opcode, in_value, in_count) and are
// accepted on a rising edge where in_valid is high and in_stall is low. Results leave
// on the out_ channel (out_element_value, out_kind, out_last) under the same rule with
// out_valid and out_stall. Every command that produces results marks its final item
// with out_last; inserts, deletes and clear produce none unless an insert is dropped.
// The front end decodes commands into a two-entry queue, so up to two commands are
// taken while the back end is busy or the receiver stalls. Inserts, front and back
// deletes and clear are carried out in the idle state. An emit of N elements streams
// one item per cycle from the store's read port while the receiver does not stall.
// A delete by value scans and then shifts, one store access per cycle. A stalled
// receiver freezes the output register and the emit stream, and the queue then
// fills and raises in_stall. Synchronous active-low reset empties the deque, the
// command queue and the result register; the store itself is not cleared and needs
// no clearing pass.
module bounded_deque_with_value_delete #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bdq_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic signed [bdq_pkg::VALUE_W-1:0] in_value,
  input  logic [bdq_pkg::COUNT_W-1:0]        in_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bdq_pkg::VALUE_W-1:0] out_element_value,
  output logic [bdq_pkg::KIND_W-1:0]         out_kind,
  output logic                               out_last
);

  // Decoded commands travel from the front end through the queue to the back end.
  bdq_pkg::cmd_t push_cmd;
  bdq_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;

  bdq_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .in_count  (in_count),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  bdq_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end owns the store and the result register that splits off the receiver.
  bdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (head_cmd),
    .cmd_valid         (!q_empty),
    .cmd_pop           (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_value (out_element_value),
    .out_kind          (out_kind),
    .out_last          (out_last)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the bounded deque with delete by value.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default capacity. The predictor below keeps its own
  // copy of the deque at the same size.
  localparam int CAP    = 32;
  localparam int SLOT_W = $clog2(CAP);

  // Field widths of the two channels.
  localparam int OPCODE_W = bdq_pkg::OPCODE_W;
  localparam int VALUE_W  = bdq_pkg::VALUE_W;
  localparam int COUNT_W  = bdq_pkg::COUNT_W;
  localparam int KIND_W   = bdq_pkg::KIND_W;

  // Least number of items driven in the whole run, directed opening included.
  localparam int TOTAL_ITEMS = 400;

  // Cycles to wait once nothing is expected any more. The longest commands in the
  // block are an emit of a full store and a delete by value.
  localparam int DRAIN_CYCLES = 64;

  // One command as it is driven onto the input channel. The opcode is a plain 4-bit
  // vector so that the unused codes can be sent too.
  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
  } command_t;

  // One item on the result channel.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    bdq_pkg::kind_t            kind;
    logic                      last;
  } result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OPCODE_W-1:0]       in_opcode = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [COUNT_W-1:0]        in_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_element_value;
  logic [KIND_W-1:0]         out_kind;
  logic                      out_last;

  bounded_deque_with_value_delete #(
    .CAPACITY(CAP)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_element_value(out_element_value),
    .out_kind         (out_kind),
    .out_last         (out_last)
  );

  // 8 ns clock period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Commands waiting to be driven, and the results the deque is expected to give.
  command_t pending_cmds[$];
  result_t  expected_results[$];

  // Private copy of the deque: a circular store, the position of the front element
  // and the number of live elements.
  logic signed [VALUE_W-1:0] dq_store [CAP];
  int                        dq_front = 0;
  int                        dq_count = 0;

  int err_count = 0;
  int accepted_items = 0;
  int stim_items = 0;

  // Handshake bookkeeping shared between the clocked processes. Each variable has
  // a single writer.
  logic in_taken = 1'b0;
  int   tx_gap_left = 0;
  int   tx_burst_left = 0;
  int   rx_left = 0;
  bit   rx_stalling = 1'b0;
  int   rx_hold_left = 0;
  int   hold_idx = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Store position of the element at logical position pos from the front.
  function automatic logic [SLOT_W-1:0] slot_of(input int pos);
    return SLOT_W'((dq_front + pos) % CAP);
  endfunction

  function automatic void push_result(input logic signed [VALUE_W-1:0] value,
                                      input bdq_pkg::kind_t kind, input logic last);
    result_t r;
    r.value = value;
    r.kind  = kind;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  // An emit gives n elements from logical position start, or a single empty-line
  // item when there is nothing to give.
  function automatic void emit_span(input int start, input int n);
    if (n == 0) begin
      push_result('0, bdq_pkg::KIND_EMPTY, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        push_result(dq_store[slot_of(start + i)], bdq_pkg::KIND_ELEMENT, i == n - 1);
      end
    end
  endfunction

  // The requested count is clamped to the capacity and then to the live elements.
  function automatic int clamp_emit(input logic [COUNT_W-1:0] count);
    int n;
    n = int'(count);
    if (n > CAP) n = CAP;
    if (n > dq_count) n = dq_count;
    return n;
  endfunction

  // Applies one accepted command to the private deque and queues its results.
  function automatic void predict_deque(input command_t c);
    bit hit;
    int n;
    hit = 1'b0;
    case (c.opcode)
      bdq_pkg::OP_ADD_FRONT: begin
        if (dq_count >= CAP) begin
          push_result('0, bdq_pkg::KIND_DROPPED, 1'b1);
        end else begin
          dq_front = (dq_front + CAP - 1) % CAP;
          dq_store[slot_of(0)] = c.value;
          dq_count++;
        end
      end
      bdq_pkg::OP_ADD_BACK: begin
        if (dq_count >= CAP) begin
          push_result('0, bdq_pkg::KIND_DROPPED, 1'b1);
        end else begin
          dq_store[slot_of(dq_count)] = c.value;
          dq_count++;
        end
      end
      bdq_pkg::OP_DEL_FRONT: begin
        if (dq_count > 0) begin
          dq_front = (dq_front + 1) % CAP;
          dq_count--;
        end
      end
      bdq_pkg::OP_DEL_BACK: begin
        if (dq_count > 0) dq_count--;
      end
      bdq_pkg::OP_CLEAR: begin
        dq_count = 0;
        dq_front = 0;
      end
      bdq_pkg::OP_DEL_VALUE: begin
        // Only the frontmost match goes; everything behind it moves up one place.
        for (int i = 0; i < dq_count; i++) begin
          if (!hit && dq_store[slot_of(i)] == c.value) begin
            hit = 1'b1;
            for (int j = i; j + 1 < dq_count; j++) begin
              dq_store[slot_of(j)] = dq_store[slot_of(j + 1)];
            end
          end
        end
        if (hit) dq_count--;
      end
      bdq_pkg::OP_EMIT_FIRST: begin
        emit_span(0, clamp_emit(c.count));
      end
      bdq_pkg::OP_EMIT_LAST: begin
        n = clamp_emit(c.count);
        emit_span(dq_count - n, n);
      end
      bdq_pkg::OP_EMIT_ALL: begin
        emit_span(0, dq_count);
      end
      default: begin
        // Unused opcodes leave the deque alone and give nothing.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap or stall length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 40));
  endfunction

  // Values come mostly from a small pool so that deletes by value find matches,
  // duplicates included; the pool holds the extremes of the field.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 35) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'sh0000_0000;
      1:       return 32'shFFFF_FFFF;
      2:       return 32'sh7FFF_FFFF;
      3:       return 32'sh8000_0000;
      4:       return 32'sh0000_0001;
      5:       return 32'sh5555_5555;
      6:       return 32'shAAAA_AAAA;
      default: return 32'sh0000_0002;
    endcase
  endfunction

  // Emit counts mostly stay within the capacity; some exceed it and get clamped.
  function automatic logic [COUNT_W-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return COUNT_W'($urandom_range(CAP + 1, 63));
    return COUNT_W'($urandom_range(0, CAP));
  endfunction

  // Queues a command; every queued item counts toward the total of the run.
  task automatic queue_cmd(input logic [OPCODE_W-1:0] opcode,
                           input logic signed [VALUE_W-1:0] value,
                           input logic [COUNT_W-1:0] count);
    command_t c;
    c.opcode = opcode;
    c.value  = value;
    c.count  = count;
    pending_cmds.push_back(c);
    stim_items++;
  endtask

  // Any command, drawn evenly over the used opcodes, with an occasional unused
  // opcode as noise.
  task automatic queue_any_cmd();
    if ($urandom_range(0, 19) == 0) begin
      queue_cmd(OPCODE_W'($urandom_range(int'(bdq_pkg::OP_EMIT_ALL) + 1, 15)), $urandom,
                COUNT_W'($urandom));
    end else begin
      queue_cmd(OPCODE_W'($urandom_range(int'(bdq_pkg::OP_ADD_FRONT),
                                         int'(bdq_pkg::OP_EMIT_ALL))),
                pick_value(), pick_count());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending commands at the falling edge with random gaps. A new
  // item is only put up once the previous one was taken, so a stalled payload holds.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : cmd_driver
    command_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap_left != 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (tx_gap_left != 0) tx_gap_left--;
      end else begin
        c = pending_cmds.pop_front();
        in_opcode <= c.opcode;
        in_value  <= c.value;
        in_count  <= c.count;
        in_valid  <= 1'b1;
        // Bursts give stretches of back-to-back items with no idling at all.
        if (tx_burst_left != 0) begin
          tx_burst_left--;
          tx_gap_left = 0;
        end else begin
          tx_gap_left = pick_gap();
          if ($urandom_range(0, 19) == 0) tx_burst_left = int'($urandom_range(10, 40));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: alternates ready runs and stall runs of random length. A long
  // hold-off from the process below is laid on top.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left != 0) begin
        rx_left--;
      end else begin
        rx_stalling = !rx_stalling;
        if (rx_stalling) rx_left = pick_gap();
        else if ($urandom_range(0, 9) == 0) rx_left = int'($urandom_range(40, 120));
        else rx_left = int'($urandom_range(0, 10));
      end
      out_stall <= rx_stalling || (rx_hold_left != 0);
    end
  end

  // Twice in the run the receiver holds off while the sender keeps offering, so the
  // block's command queue fills and it has to raise in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_idx < 2 && accepted_items >= 120 + 200 * hold_idx) begin
      rx_hold_left <= 400;
      hold_idx     <= hold_idx + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge an accepted command updates the prediction and
  // an accepted result is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_result();
    result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: element_value %h, kind %0d, last %0d",
             out_element_value, out_kind, out_last);
      err_count++;
    end else begin
      exp_r = expected_results.pop_front();
      if (out_element_value !== exp_r.value) begin
        $error("element_value: expected %h, got %h", exp_r.value, out_element_value);
        err_count++;
      end
      if (out_kind !== exp_r.kind) begin
        $error("kind: expected %0d, got %0d", exp_r.kind, out_kind);
        err_count++;
      end
      if (out_last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, out_last);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    command_t c;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        c.opcode = in_opcode;
        c.value  = in_value;
        c.count  = in_count;
        predict_deque(c);
        accepted_items <= accepted_items + 1;
      end
      if (out_valid && !out_stall) check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, reset, wait for everything to drain.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed opening. Removes and emits on an empty deque come first.
    queue_cmd(bdq_pkg::OP_EMIT_ALL, '0, '0);
    queue_cmd(bdq_pkg::OP_DEL_FRONT, '0, '0);
    queue_cmd(bdq_pkg::OP_DEL_BACK, '0, '0);
    queue_cmd(bdq_pkg::OP_DEL_VALUE, '0, '0);
    // Build 1, min, max, -1, 0 from both ends; the front insert wraps the store.
    queue_cmd(bdq_pkg::OP_ADD_BACK, 32'sh7FFF_FFFF, '0);
    queue_cmd(bdq_pkg::OP_ADD_FRONT, 32'sh8000_0000, '0);
    queue_cmd(bdq_pkg::OP_ADD_BACK, 32'shFFFF_FFFF, '0);
    queue_cmd(bdq_pkg::OP_ADD_BACK, 32'sh0000_0000, '0);
    queue_cmd(bdq_pkg::OP_ADD_FRONT, 32'sh0000_0001, '0);
    // A zero count gives an empty line; counts beyond the contents are clamped.
    queue_cmd(bdq_pkg::OP_EMIT_FIRST, '0, '0);
    queue_cmd(bdq_pkg::OP_EMIT_FIRST, '0, 6'd2);
    queue_cmd(bdq_pkg::OP_EMIT_LAST, '0, 6'd3);
    queue_cmd(bdq_pkg::OP_EMIT_LAST, '0, 6'd63);
    queue_cmd(bdq_pkg::OP_EMIT_FIRST, '0, 6'd32);
    // Delete by value at the tail, at the front, with no match and in the middle.
    queue_cmd(bdq_pkg::OP_DEL_VALUE, 32'sh0000_0000, '0);
    queue_cmd(bdq_pkg::OP_DEL_VALUE, 32'sh0000_0001, '0);
    queue_cmd(bdq_pkg::OP_DEL_VALUE, 32'sh0000_3039, '0);
    queue_cmd(bdq_pkg::OP_DEL_VALUE, 32'sh7FFF_FFFF, '0);
    queue_cmd(bdq_pkg::OP_EMIT_ALL, '0, '0);
    // Remove the back twice, the second time from a one-element deque.
    queue_cmd(bdq_pkg::OP_DEL_BACK, '0, '0);
    queue_cmd(bdq_pkg::OP_DEL_BACK, '0, '0);
    queue_cmd(bdq_pkg::OP_EMIT_ALL, '0, '0);
    queue_cmd(bdq_pkg::OP_ADD_FRONT, 32'sh0000_0005, '0);
    queue_cmd(bdq_pkg::OP_CLEAR, '0, '0);
    queue_cmd(bdq_pkg::OP_EMIT_LAST, '0, 6'd4);
    // Unused opcodes must be ignored.
    queue_cmd(4'd9, 32'sh1234_5678, 6'd63);
    queue_cmd(4'd15, 32'shFFFF_FFFF, 6'd63);

    // Random part, built from short sequences. Fill runs can push the deque to full and
    // past it, drain runs shrink it again, and mixed runs hit everything else.
    while (stim_items < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(8, 40)) begin
            queue_cmd($urandom_range(0, 1) ? bdq_pkg::OP_ADD_FRONT : bdq_pkg::OP_ADD_BACK,
                      pick_value(), '0);
          end
          queue_cmd(OPCODE_W'($urandom_range(int'(bdq_pkg::OP_EMIT_FIRST),
                                             int'(bdq_pkg::OP_EMIT_ALL))),
                    '0, pick_count());
        end
        2, 3: begin
          repeat ($urandom_range(4, 20)) begin
            case ($urandom_range(0, 3))
              0:       queue_cmd(bdq_pkg::OP_DEL_FRONT, $urandom, COUNT_W'($urandom));
              1:       queue_cmd(bdq_pkg::OP_DEL_BACK, $urandom, COUNT_W'($urandom));
              default: queue_cmd(bdq_pkg::OP_DEL_VALUE, pick_value(), COUNT_W'($urandom));
            endcase
          end
          queue_cmd(bdq_pkg::OP_EMIT_ALL, $urandom, COUNT_W'($urandom));
        end
        4: begin
          queue_cmd(bdq_pkg::OP_CLEAR, $urandom, COUNT_W'($urandom));
          repeat ($urandom_range(1, 6)) queue_any_cmd();
        end
        default: begin
          repeat ($urandom_range(4, 10)) queue_any_cmd();
        end
      endcase
    end

    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every command has been taken, then until every expected result has
    // arrived. Commands that give no result may still be in the block, so let it run
    // a little longer so that any stray result shows up.
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("[bounded_deque_with_value_delete] OK");
    end else begin
      $display("[bounded_deque_with_value_delete] ERROR");
    end
    $finish;
  end

  // Watchdog. A correct run with every emit full and every result stalled its
  // longest still ends well below this limit.
  initial begin
    #40_000_000;
    $display("[bounded_deque_with_value_delete] ERROR");
    $finish;
  end

endmodule
